// ----- design/pfs_pkg.sv -----
// shared types and constants for the palette fade stepper
package pfs_pkg;

  localparam int PALETTE_ENTRIES_DEF = 64;

  localparam int CFG_W = 7;
  localparam logic [CFG_W-1:0] ENTRIES_RST = 7'd64;

  localparam int CHAN_W = 8;
  localparam logic [CHAN_W-1:0] FADE_STEP = 8'h22;
  localparam logic [CHAN_W-1:0] CHAN_MAX  = 8'hFF;

  localparam int IN_DATA_W  = 40;
  localparam int OUT_DATA_W = 32;

  // opcodes
  localparam logic [2:0] OP_WR_CUR    = 3'd0;
  localparam logic [2:0] OP_WR_TGT    = 3'd1;
  localparam logic [2:0] OP_RD_CUR    = 3'd2;
  localparam logic [2:0] OP_IN_BLACK  = 3'd3;
  localparam logic [2:0] OP_OUT_BLACK = 3'd4;
  localparam logic [2:0] OP_IN_WHITE  = 3'd5;
  localparam logic [2:0] OP_OUT_WHITE = 3'd6;

  typedef enum logic [3:0] {
    S_IDLE,
    S_CMD_WR,
    S_RD,
    S_RD_WAIT,
    S_READ,
    S_LOAD,
    S_CHAN,
    S_WRITE,
    S_DONE
  } pfs_state_t;

  // result of one channel step
  typedef struct packed {
    logic [CHAN_W-1:0] val;
    logic              cont;
  } pfs_step_t;

endpackage

// ----- design/pfs_ram.sv -----
// generic single-write, single-read ram with registered read data
module pfs_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 64
) (
  input  logic                                       clk,
  input  logic                                       we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                           wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                           rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ----- design/pfs_chan_step.sv -----
// shared unit: moves one channel by the fade step toward its goal, clamped
module pfs_chan_step (
  input  logic [7:0]         val_i,
  input  logic [7:0]         goal_i,
  input  logic               rising_i,
  output pfs_pkg::pfs_step_t step_o
);
  import pfs_pkg::*;

  logic [8:0] v9;
  logic [8:0] g9;
  logic [8:0] up9;
  logic [8:0] lim9;

  assign v9   = {1'b0, val_i};
  assign g9   = {1'b0, goal_i};
  assign up9  = v9 + {1'b0, FADE_STEP};
  assign lim9 = g9 + {1'b0, FADE_STEP};

  always_comb begin
    step_o.val  = val_i;
    step_o.cont = 1'b1;
    if (rising_i) begin
      if (v9 < g9) begin
        if (up9 >= g9) begin
          step_o.val = goal_i;
        end else begin
          step_o.val  = up9[7:0];
          step_o.cont = 1'b0;
        end
      end
    end else begin
      if (v9 > g9) begin
        // value minus step at or below goal
        if (v9 <= lim9) begin
          step_o.val = goal_i;
        end else begin
          step_o.val  = val_i - FADE_STEP;
          step_o.cont = 1'b0;
        end
      end
    end
  end

endmodule

// ----- design/palette_fade_stepper.sv -----
// top level: palette store, command sequencer and fade engine
//
// palette fade stepper: holds a current and a target rgb palette and runs
// one command per input item, giving exactly one result item each. write
// commands load an entry of either palette, a read returns the current
// entry, and each fade step walks entries 0 to entries_in_use-1
// (clamped to the palette size), moving each entry one channel at a
// time by 0x22 toward black, white or the target entry. each entry
// takes one ram read, one load, one to three passes through the single
// shared channel-step unit, and one write back. in_tready is high only
// while the sequencer is idle; a finished result sits in the output
// register so the next item may be taken before it is drained. both
// palettes read as zero after reset through per-entry valid bits, so no
// clearing pass is needed. the user must write entries_in_use through
// cfg_wr_en / cfg_wr_data only while the block is idle; the block does
// not enforce this.
module palette_fade_stepper #(
  parameter int PALETTE_ENTRIES = pfs_pkg::PALETTE_ENTRIES_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  // opcode[2:0], entry_index[8:3], red_in[16:9], green_in[24:17],
  // blue_in[32:25], zero fill above
  input  logic [pfs_pkg::IN_DATA_W-1:0]   in_tdata,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  // fade_done[0], red_out[8:1], green_out[16:9], blue_out[24:17],
  // zero fill above
  output logic [pfs_pkg::OUT_DATA_W-1:0]  out_tdata,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  input  logic                            cfg_wr_en,
  input  logic [pfs_pkg::CFG_W-1:0]       cfg_wr_data
);
  import pfs_pkg::*;

  localparam int AW   = (PALETTE_ENTRIES > 1) ? $clog2(PALETTE_ENTRIES) : 1;
  localparam int CNTW = $clog2(PALETTE_ENTRIES + 1);
  localparam int CMPW = (CNTW > CFG_W) ? CNTW : CFG_W;
  localparam int RGBW = 3 * CHAN_W;

  // configuration
  logic [CFG_W-1:0] cfg_entries_r;

  // sequencer
  pfs_state_t state_r, state_nxt;

  // latched item
  logic [2:0]        op_r;
  logic [5:0]        idx_r;
  logic [RGBW-1:0]   rgb_r;
  logic              rng_r;

  // fade engine
  logic [CNTW-1:0]   ent_r;
  logic [1:0]        k_r;
  logic [CHAN_W-1:0] ch_r   [3];
  logic [CHAN_W-1:0] goal_r [3];
  logic              fade_ok_r;
  logic [RGBW-1:0]   res_rgb_r;

  // output register
  logic              out_tvalid_r;
  logic              out_done_r;
  logic [RGBW-1:0]   out_rgb_r;

  // valid bits, one per entry
  logic [PALETTE_ENTRIES-1:0] cur_vld_r;
  logic [PALETTE_ENTRIES-1:0] tgt_vld_r;
  logic              cur_rv_r;
  logic              tgt_rv_r;

  // memories
  logic              cur_we;
  logic [AW-1:0]     cur_waddr;
  logic [RGBW-1:0]   cur_wdata;
  logic              tgt_we;
  logic [AW-1:0]     rd_addr;
  logic [RGBW-1:0]   cur_rdata;
  logic [RGBW-1:0]   tgt_rdata;
  logic [RGBW-1:0]   cur_word;
  logic [RGBW-1:0]   tgt_word;

  // item fields
  logic [2:0]        f_op;
  logic [5:0]        f_idx;
  logic              f_rng;
  logic              in_acc;
  logic              in_fade;
  logic [AW-1:0]     idx_addr;
  logic [AW-1:0]     ent_addr;

  // walk length
  logic [CMPW-1:0]   cfg_ext;
  logic [CMPW-1:0]   lim_ext;
  logic [CNTW-1:0]   n_lim;
  logic [CNTW-1:0]   ent_inc;

  // channel step
  logic              fade_in;
  logic              rising;
  logic [1:0]        pos;
  pfs_step_t         step;
  logic              out_free;
  logic              is_fade_op;

  assign f_op   = in_tdata[2:0];
  assign f_idx  = in_tdata[8:3];
  assign f_rng  = (CMPW'(f_idx) < CMPW'(PALETTE_ENTRIES));
  assign in_acc = in_tvalid && in_tready;
  assign in_fade = (f_op == OP_IN_BLACK) || (f_op == OP_OUT_BLACK) ||
                   (f_op == OP_IN_WHITE) || (f_op == OP_OUT_WHITE);

  assign idx_addr = AW'(idx_r);
  assign ent_addr = ent_r[AW-1:0];

  assign cfg_ext = CMPW'(cfg_entries_r);
  assign lim_ext = (cfg_ext > CMPW'(PALETTE_ENTRIES)) ? CMPW'(PALETTE_ENTRIES) : cfg_ext;
  assign n_lim   = CNTW'(lim_ext);
  assign ent_inc = ent_r + CNTW'(1);

  assign is_fade_op = (op_r == OP_IN_BLACK) || (op_r == OP_OUT_BLACK) ||
                      (op_r == OP_IN_WHITE) || (op_r == OP_OUT_WHITE);
  assign fade_in = (op_r == OP_IN_BLACK) || (op_r == OP_IN_WHITE);
  assign rising  = (op_r == OP_IN_BLACK) || (op_r == OP_OUT_WHITE);
  // fade-ins go blue, green, red; fade-outs red, green, blue
  assign pos     = fade_in ? (2'd2 - k_r) : k_r;
  assign out_free = !out_tvalid_r || out_tready;

  // entries never written read as zero
  assign cur_word = cur_rv_r ? cur_rdata : '0;
  assign tgt_word = tgt_rv_r ? tgt_rdata : '0;

  pfs_chan_step u_step (
    .val_i    (ch_r[pos]),
    .goal_i   (goal_r[pos]),
    .rising_i (rising),
    .step_o   (step)
  );

  pfs_ram #(.WIDTH(RGBW), .DEPTH(PALETTE_ENTRIES)) u_cur_ram (
    .clk   (clk),
    .we    (cur_we),
    .waddr (cur_waddr),
    .wdata (cur_wdata),
    .raddr (rd_addr),
    .rdata (cur_rdata)
  );

  pfs_ram #(.WIDTH(RGBW), .DEPTH(PALETTE_ENTRIES)) u_tgt_ram (
    .clk   (clk),
    .we    (tgt_we),
    .waddr (idx_addr),
    .wdata (rgb_r),
    .raddr (rd_addr),
    .rdata (tgt_rdata)
  );

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          if ((f_op == OP_WR_CUR) || (f_op == OP_WR_TGT)) begin
            state_nxt = S_CMD_WR;
          end else if (f_op == OP_RD_CUR) begin
            state_nxt = S_RD;
          end else if (in_fade && (n_lim != '0)) begin
            state_nxt = S_READ;
          end else begin
            state_nxt = S_DONE;
          end
        end
      end
      S_CMD_WR:  state_nxt = S_DONE;
      S_RD:      state_nxt = S_RD_WAIT;
      S_RD_WAIT: state_nxt = S_DONE;
      S_READ:    state_nxt = S_LOAD;
      S_LOAD:    state_nxt = S_CHAN;
      S_CHAN: begin
        if (!step.cont || (k_r == 2'd2)) begin
          state_nxt = S_WRITE;
        end
      end
      S_WRITE:   state_nxt = (ent_inc == n_lim) ? S_DONE : S_READ;
      S_DONE: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default:   state_nxt = S_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    in_tready = 1'b0;
    cur_we    = 1'b0;
    tgt_we    = 1'b0;
    cur_waddr = ent_addr;
    cur_wdata = {ch_r[0], ch_r[1], ch_r[2]};
    rd_addr   = ent_addr;
    case (state_r)
      S_IDLE:   in_tready = 1'b1;
      S_CMD_WR: begin
        cur_waddr = idx_addr;
        cur_wdata = rgb_r;
        cur_we    = rng_r && (op_r == OP_WR_CUR);
        tgt_we    = rng_r && (op_r == OP_WR_TGT);
      end
      S_RD:     rd_addr = idx_addr;
      S_WRITE:  cur_we = 1'b1;
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_IDLE;
      cfg_entries_r <= ENTRIES_RST;
      cur_vld_r     <= '0;
      tgt_vld_r     <= '0;
      out_tvalid_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_wr_en) begin
        cfg_entries_r <= cfg_wr_data;
      end
      if (cur_we) begin
        cur_vld_r[cur_waddr] <= 1'b1;
      end
      if (tgt_we) begin
        tgt_vld_r[idx_addr] <= 1'b1;
      end
      if (state_r == S_DONE && out_free) begin
        out_tvalid_r <= 1'b1;
      end else if (out_tready) begin
        out_tvalid_r <= 1'b0;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    cur_rv_r <= cur_vld_r[rd_addr];
    tgt_rv_r <= tgt_vld_r[rd_addr];
    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          op_r      <= f_op;
          idx_r     <= f_idx;
          rng_r     <= f_rng;
          // palette words hold red, green, blue from the high byte down
          rgb_r     <= {in_tdata[16:9], in_tdata[24:17], in_tdata[32:25]};
          res_rgb_r <= '0;
          fade_ok_r <= 1'b1;
          ent_r     <= '0;
        end
      end
      S_RD_WAIT: begin
        if (rng_r) begin
          res_rgb_r <= cur_word;
        end
      end
      S_LOAD: begin
        k_r     <= '0;
        ch_r[0] <= cur_word[23:16];
        ch_r[1] <= cur_word[15:8];
        ch_r[2] <= cur_word[7:0];
        for (int c = 0; c < 3; c++) begin
          if (op_r == OP_OUT_BLACK) begin
            goal_r[c] <= '0;
          end else if (op_r == OP_OUT_WHITE) begin
            goal_r[c] <= CHAN_MAX;
          end else begin
            goal_r[c] <= tgt_word[(2-c)*CHAN_W +: CHAN_W];
          end
        end
      end
      S_CHAN: begin
        ch_r[pos] <= step.val;
        k_r       <= k_r + 2'd1;
        if (!step.cont) begin
          fade_ok_r <= 1'b0;
        end
      end
      S_WRITE:  ent_r <= ent_inc;
      S_DONE: begin
        if (out_free) begin
          out_done_r <= is_fade_op && fade_ok_r;
          out_rgb_r  <= res_rgb_r;
        end
      end
      default: begin
      end
    endcase
  end

  // res_rgb_r holds blue, green, red from the low byte up
  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = {{(OUT_DATA_W - RGBW - 1){1'b0}}, out_rgb_r[7:0],
                       out_rgb_r[15:8], out_rgb_r[23:16], out_done_r};

  a_accept_leaves_idle : assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> state_r != S_IDLE)
    else $error("accepted item did not start the sequencer");

  a_walk_in_range : assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CHAN) || (state_r == S_WRITE) |-> ent_r < n_lim)
    else $error("fade walk beyond entries in use");

  a_result_from_done : assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid_r) |-> $past(state_r) == S_DONE)
    else $error("result raised outside done state");

  a_done_hands_off : assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DONE) && out_free |=> out_tvalid_r && (state_r == S_IDLE))
    else $error("finished result not handed to output register");

endmodule
